// ===== design/psched_pkg.sv =====
// Shared types and constants for the priority and delay scheduler.
package psched_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int PRIO_W      = 8;
  localparam int LEFT_W      = 10;
  localparam int OP_W        = 2;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ID_W-1:0]   id_t;
  typedef logic [PRIO_W-1:0] prio_t;
  typedef logic [LEFT_W-1:0] left_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_RERUN = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    id_t   id;
    prio_t prio;
  } rdy_ent_t;

  typedef struct packed {
    id_t   id;
    prio_t prio;
    left_t due;
  } dly_ent_t;

  localparam int RDY_W = $bits(rdy_ent_t);
  localparam int DLY_W = $bits(dly_ent_t);

  localparam cnt_t FULL_CNT = cnt_t'(QUEUE_DEPTH);
  localparam ptr_t LAST_PTR = ptr_t'(QUEUE_DEPTH - 1);

  // Physical slot of logical position k in a ring starting at head.
  function automatic ptr_t phys(input ptr_t head, input ptr_t k);
    logic [PTR_W:0] sum;
    sum = {1'b0, head} + {1'b0, k};
    if (sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (PTR_W+1)'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

endpackage

// ===== design/psched_in_if.sv =====
// Request channel of the scheduler.
interface psched_in_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  psched_pkg::id_t        task_id;
  psched_pkg::prio_t      priority_req;
  psched_pkg::left_t      delay_ticks;

  modport source (output valid, opcode, task_id, priority_req, delay_ticks, input ready);
  modport sink   (input valid, opcode, task_id, priority_req, delay_ticks, output ready);
endinterface

// ===== design/psched_out_if.sv =====
// Result channel of the scheduler.
interface psched_out_if;
  logic                   valid;
  logic                   ready;
  logic                   run_valid;
  psched_pkg::id_t        run_task;
  psched_pkg::prio_t      run_priority;
  logic                   dropped;
  logic                   all_done;

  modport source (output valid, run_valid, run_task, run_priority, dropped, all_done,
                  input ready);
  modport sink   (input valid, run_valid, run_task, run_priority, dropped, all_done,
                  output ready);
endinterface

// ===== design/psched_ram.sv =====
// Simple dual-port RAM with registered read data.
module psched_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [DATA_W-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [DATA_W-1:0]                        rdata
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/priority_ready_and_delay_scheduler.sv =====
// Top level of the priority ready queue and delay queue scheduler.
//
// Usage: requests arrive on in_ch (valid/ready); each transfer carries an opcode
// (add, tick, rerun, no-op) and its operands. Exactly one result per request
// leaves on out_ch (valid/ready) with run_valid, run_task, run_priority, dropped
// and all_done.
// Both queues live in RAMs with registered read data and are kept sorted as
// rings: insertion walks from the tail toward the head, one entry at a time
// (read, then compare and write back). Delay entries store an absolute due time
// against a tick counter stepped once per tick, so a tick touches only expired heads.
// An add or rerun walks its queue until the entry finds its place; a rerun with
// no running task and a no-op go straight to the result. A tick moves expired
// delay heads to the ready queue, advances the tick counter and pops the ready head.
// One request is in work at a time; in_ch.ready is high only between requests.
// The result sits in an output register, so the next request is taken while a
// result still waits; if the receiver stalls and the register is full, a
// finished request holds until the result is taken.
// Reset (rst_n low, synchronous) empties both queues, clears the running task
// and the output register. RAM contents need no clearing.
module priority_ready_and_delay_scheduler (
  input  logic         clk,
  input  logic         rst_n,
  psched_in_if.sink    in_ch,
  psched_out_if.source out_ch
);

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b0000000001,
    ST_INS_START = 10'b0000000010,
    ST_INS_RD    = 10'b0000000100,
    ST_INS_CMP   = 10'b0000001000,
    ST_INS_LAST  = 10'b0000010000,
    ST_D_RD      = 10'b0000100000,
    ST_D_CHK     = 10'b0001000000,
    ST_T_ADV     = 10'b0010000000,
    ST_R_POP     = 10'b0100000000,
    ST_DONE      = 10'b1000000000
  } state_t;

  state_t                  state_r, state_nxt;
  psched_pkg::op_t         op_r, op_nxt;
  psched_pkg::cnt_t        rcnt_r, rcnt_nxt, dcnt_r, dcnt_nxt;
  psched_pkg::ptr_t        rhead_r, rhead_nxt, dhead_r, dhead_nxt;
  psched_pkg::ptr_t        k_r, k_nxt;
  psched_pkg::left_t       now_r, now_nxt;
  psched_pkg::id_t         run_id_r, run_id_nxt, ins_id_r, ins_id_nxt;
  psched_pkg::prio_t       run_prio_r, run_prio_nxt, ins_prio_r, ins_prio_nxt;
  psched_pkg::left_t       ins_left_r, ins_left_nxt;
  logic                    ins_dly_r, ins_dly_nxt;
  logic                    run_vld_r, run_vld_nxt;
  logic                    rv_r, rv_nxt, drop_r, drop_nxt;
  psched_pkg::id_t         rt_r, rt_nxt;
  psched_pkg::prio_t       rp_r, rp_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    o_rv_r, o_rv_nxt, o_drop_r, o_drop_nxt, o_done_r, o_done_nxt;
  psched_pkg::id_t         o_task_r, o_task_nxt;
  psched_pkg::prio_t       o_prio_r, o_prio_nxt;

  logic                    r_we, d_we;
  psched_pkg::ptr_t        r_waddr, r_raddr, d_waddr, d_raddr;
  psched_pkg::rdy_ent_t    r_wdata, r_rd;
  psched_pkg::dly_ent_t    d_wdata, d_rd;
  logic [psched_pkg::RDY_W-1:0] r_rdata;
  logic [psched_pkg::DLY_W-1:0] d_rdata;

  psched_pkg::cnt_t        cnt;
  psched_pkg::ptr_t        head;
  psched_pkg::ptr_t        slot_up;
  psched_pkg::left_t       rd_left;
  logic                    stop;
  state_t                  ret_st;

  psched_ram #(.DATA_W(psched_pkg::RDY_W), .DEPTH(psched_pkg::QUEUE_DEPTH)) u_rdy_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  psched_ram #(.DATA_W(psched_pkg::DLY_W), .DEPTH(psched_pkg::QUEUE_DEPTH)) u_dly_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  assign r_rd = psched_pkg::rdy_ent_t'(r_rdata);
  assign d_rd = psched_pkg::dly_ent_t'(d_rdata);

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.run_valid    = o_rv_r;
  assign out_ch.run_task     = o_task_r;
  assign out_ch.run_priority = o_prio_r;
  assign out_ch.dropped      = o_drop_r;
  assign out_ch.all_done     = o_done_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    rcnt_nxt      = rcnt_r;
    dcnt_nxt      = dcnt_r;
    rhead_nxt     = rhead_r;
    dhead_nxt     = dhead_r;
    k_nxt         = k_r;
    now_nxt       = now_r;
    run_id_nxt    = run_id_r;
    run_prio_nxt  = run_prio_r;
    run_vld_nxt   = run_vld_r;
    ins_id_nxt    = ins_id_r;
    ins_prio_nxt  = ins_prio_r;
    ins_left_nxt  = ins_left_r;
    ins_dly_nxt   = ins_dly_r;
    rv_nxt        = rv_r;
    rt_nxt        = rt_r;
    rp_nxt        = rp_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r;
    o_rv_nxt      = o_rv_r;
    o_task_nxt    = o_task_r;
    o_prio_nxt    = o_prio_r;
    o_drop_nxt    = o_drop_r;
    o_done_nxt    = o_done_r;

    r_we    = 1'b0;
    d_we    = 1'b0;
    r_waddr = '0;
    d_waddr = '0;
    r_raddr = '0;
    d_raddr = '0;
    r_wdata = '{id: ins_id_r, prio: ins_prio_r};
    d_wdata = '{id: ins_id_r, prio: ins_prio_r, due: now_r + ins_left_r};

    cnt     = ins_dly_r ? dcnt_r : rcnt_r;
    head    = ins_dly_r ? dhead_r : rhead_r;
    slot_up = psched_pkg::phys(head, k_r + 1'b1);
    rd_left = d_rd.due - now_r;
    stop    = ins_dly_r ? (rd_left <= ins_left_r) : (r_rd.prio >= ins_prio_r);
    ret_st  = (op_r == psched_pkg::OP_TICK) ? ST_D_RD : ST_DONE;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt   = psched_pkg::op_t'(in_ch.opcode);
          rv_nxt   = 1'b0;
          rt_nxt   = '0;
          rp_nxt   = '0;
          drop_nxt = 1'b0;
          state_nxt = ST_DONE;
          case (psched_pkg::op_t'(in_ch.opcode))
            psched_pkg::OP_ADD: begin
              ins_id_nxt   = in_ch.task_id;
              ins_prio_nxt = in_ch.priority_req;
              ins_dly_nxt  = 1'b0;
              state_nxt    = ST_INS_START;
            end
            psched_pkg::OP_TICK: begin
              state_nxt = ST_D_RD;
            end
            psched_pkg::OP_RERUN: begin
              if (run_vld_r) begin
                run_vld_nxt  = 1'b0;
                ins_id_nxt   = run_id_r;
                ins_prio_nxt = run_prio_r;
                ins_left_nxt = in_ch.delay_ticks;
                ins_dly_nxt  = (in_ch.delay_ticks != '0);
                state_nxt    = ST_INS_START;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_INS_START: begin
        if (cnt == psched_pkg::FULL_CNT) begin
          drop_nxt  = 1'b1;
          state_nxt = ret_st;
        end else if (cnt == '0) begin
          r_we      = !ins_dly_r;
          d_we      = ins_dly_r;
          r_waddr   = head;
          d_waddr   = head;
          if (ins_dly_r) dcnt_nxt = dcnt_r + 1'b1;
          else           rcnt_nxt = rcnt_r + 1'b1;
          state_nxt = ret_st;
        end else begin
          k_nxt     = psched_pkg::ptr_t'(cnt - 1'b1);
          state_nxt = ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        r_raddr   = psched_pkg::phys(head, k_r);
        d_raddr   = psched_pkg::phys(head, k_r);
        state_nxt = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        r_we    = !ins_dly_r;
        d_we    = ins_dly_r;
        r_waddr = slot_up;
        d_waddr = slot_up;
        if (stop) begin
          if (ins_dly_r) dcnt_nxt = dcnt_r + 1'b1;
          else           rcnt_nxt = rcnt_r + 1'b1;
          state_nxt = ret_st;
        end else begin
          r_wdata = r_rd;
          d_wdata = d_rd;
          if (k_r == '0) begin
            state_nxt = ST_INS_LAST;
          end else begin
            k_nxt     = k_r - 1'b1;
            state_nxt = ST_INS_RD;
          end
        end
      end
      ST_INS_LAST: begin
        r_we    = !ins_dly_r;
        d_we    = ins_dly_r;
        r_waddr = head;
        d_waddr = head;
        if (ins_dly_r) dcnt_nxt = dcnt_r + 1'b1;
        else           rcnt_nxt = rcnt_r + 1'b1;
        state_nxt = ret_st;
      end
      ST_D_RD: begin
        d_raddr   = dhead_r;
        state_nxt = (dcnt_r == '0) ? ST_T_ADV : ST_D_CHK;
      end
      ST_D_CHK: begin
        if (rd_left == '0) begin
          dhead_nxt    = psched_pkg::ptr_inc(dhead_r);
          dcnt_nxt     = dcnt_r - 1'b1;
          ins_id_nxt   = d_rd.id;
          ins_prio_nxt = d_rd.prio;
          ins_dly_nxt  = 1'b0;
          state_nxt    = ST_INS_START;
        end else begin
          state_nxt = ST_T_ADV;
        end
      end
      ST_T_ADV: begin
        now_nxt = now_r + 1'b1;
        r_raddr = rhead_r;
        if (rcnt_r == '0) begin
          run_vld_nxt = 1'b0;
          state_nxt   = ST_DONE;
        end else begin
          state_nxt = ST_R_POP;
        end
      end
      ST_R_POP: begin
        run_id_nxt   = r_rd.id;
        run_prio_nxt = r_rd.prio;
        run_vld_nxt  = 1'b1;
        rhead_nxt    = psched_pkg::ptr_inc(rhead_r);
        rcnt_nxt     = rcnt_r - 1'b1;
        rv_nxt       = 1'b1;
        rt_nxt       = r_rd.id;
        rp_nxt       = r_rd.prio;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_rv_nxt      = rv_r;
          o_task_nxt    = rt_r;
          o_prio_nxt    = rp_r;
          o_drop_nxt    = drop_r;
          o_done_nxt    = (rcnt_r == '0) && (dcnt_r == '0);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rcnt_r      <= '0;
      dcnt_r      <= '0;
      rhead_r     <= '0;
      dhead_r     <= '0;
      now_r       <= '0;
      run_id_r    <= '0;
      run_prio_r  <= '0;
      run_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rcnt_r      <= rcnt_nxt;
      dcnt_r      <= dcnt_nxt;
      rhead_r     <= rhead_nxt;
      dhead_r     <= dhead_nxt;
      now_r       <= now_nxt;
      run_id_r    <= run_id_nxt;
      run_prio_r  <= run_prio_nxt;
      run_vld_r   <= run_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    k_r        <= k_nxt;
    ins_id_r   <= ins_id_nxt;
    ins_prio_r <= ins_prio_nxt;
    ins_left_r <= ins_left_nxt;
    ins_dly_r  <= ins_dly_nxt;
    rv_r       <= rv_nxt;
    rt_r       <= rt_nxt;
    rp_r       <= rp_nxt;
    drop_r     <= drop_nxt;
    o_rv_r     <= o_rv_nxt;
    o_task_r   <= o_task_nxt;
    o_prio_r   <= o_prio_nxt;
    o_drop_r   <= o_drop_nxt;
    o_done_r   <= o_done_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (rcnt_r <= psched_pkg::FULL_CNT) && (dcnt_r <= psched_pkg::FULL_CNT))
    else $error("queue count beyond depth");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_R_POP) |-> (rcnt_r != '0))
    else $error("pop from empty ready queue");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r != ST_IDLE))
    else $error("request transfer did not start work");

endmodule

// ===== test/psched_tb_pkg.sv =====
`timescale 1ns / 1ps
// Stimulus row type shared by the scheduler testbench.
package psched_tb_pkg;
  import psched_pkg::*;

  typedef struct {
    op_t   op;
    id_t   id;
    prio_t prio;
    left_t ticks;
    bit    has_exp;
    bit    e_run;
    id_t   e_task;
    prio_t e_prio;
    bit    e_drop;
    bit    e_done;
  } sched_row_t;

  typedef struct packed {
    logic  run_valid;
    id_t   run_task;
    prio_t run_priority;
    logic  dropped;
    logic  all_done;
  } sched_res_t;
endpackage

// ===== test/priority_ready_and_delay_scheduler_test.sv =====
`timescale 1ns / 1ps
// Testbench for the priority ready and delay scheduler: directed table, random traffic.
module priority_ready_and_delay_scheduler_test;
  import psched_pkg::*;
  import psched_tb_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  psched_in_if  in_ch ();
  psched_out_if out_ch ();

  priority_ready_and_delay_scheduler dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  id_t   rq_id   [QUEUE_DEPTH];
  prio_t rq_prio [QUEUE_DEPTH];
  int    rq_cnt;
  id_t   dq_id   [QUEUE_DEPTH];
  prio_t dq_prio [QUEUE_DEPTH];
  left_t dq_left [QUEUE_DEPTH];
  int    dq_cnt;
  id_t   cur_id;
  prio_t cur_prio;
  bit    cur_valid;

  sched_res_t pending_results[$];
  int  errors;
  int  idle_cycles;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  sending;

  function automatic bit ready_enqueue(id_t id, prio_t pr);
    int pos;
    pos = 0;
    if (rq_cnt >= QUEUE_DEPTH) return 0;
    while (pos < rq_cnt && rq_prio[pos] >= pr) pos++;
    for (int k = rq_cnt; k > pos; k--) begin
      rq_id[k]   = rq_id[k-1];
      rq_prio[k] = rq_prio[k-1];
    end
    rq_id[pos]   = id;
    rq_prio[pos] = pr;
    rq_cnt++;
    return 1;
  endfunction

  function automatic bit delay_enqueue(id_t id, prio_t pr, left_t lf);
    int pos;
    pos = 0;
    if (dq_cnt >= QUEUE_DEPTH) return 0;
    while (pos < dq_cnt && dq_left[pos] <= lf) pos++;
    for (int k = dq_cnt; k > pos; k--) begin
      dq_id[k]   = dq_id[k-1];
      dq_prio[k] = dq_prio[k-1];
      dq_left[k] = dq_left[k-1];
    end
    dq_id[pos]   = id;
    dq_prio[pos] = pr;
    dq_left[pos] = lf;
    dq_cnt++;
    return 1;
  endfunction

  function automatic sched_res_t schedule_step(op_t op, id_t id, prio_t pr, left_t tk);
    sched_res_t r;
    id_t   mid;
    prio_t mpr;
    r = '0;
    case (op)
      OP_ADD: begin
        if (!ready_enqueue(id, pr)) r.dropped = 1;
      end
      OP_TICK: begin
        while (dq_cnt > 0 && dq_left[0] == 0) begin
          mid = dq_id[0];
          mpr = dq_prio[0];
          for (int k = 1; k < dq_cnt; k++) begin
            dq_id[k-1]   = dq_id[k];
            dq_prio[k-1] = dq_prio[k];
            dq_left[k-1] = dq_left[k];
          end
          dq_cnt--;
          if (!ready_enqueue(mid, mpr)) r.dropped = 1;
        end
        for (int k = 0; k < dq_cnt; k++) dq_left[k] = dq_left[k] - 1'b1;
        if (rq_cnt > 0) begin
          cur_id    = rq_id[0];
          cur_prio  = rq_prio[0];
          cur_valid = 1;
          for (int k = 1; k < rq_cnt; k++) begin
            rq_id[k-1]   = rq_id[k];
            rq_prio[k-1] = rq_prio[k];
          end
          rq_cnt--;
          r.run_valid    = 1;
          r.run_task     = cur_id;
          r.run_priority = cur_prio;
        end else begin
          cur_valid = 0;
        end
      end
      OP_RERUN: begin
        if (cur_valid) begin
          if (tk == 0) begin
            if (!ready_enqueue(cur_id, cur_prio)) r.dropped = 1;
          end else begin
            if (!delay_enqueue(cur_id, cur_prio, tk)) r.dropped = 1;
          end
          cur_valid = 0;
        end
      end
      default: ;
    endcase
    r.all_done = (rq_cnt == 0 && dq_cnt == 0);
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(op_t op, id_t id, prio_t pr, left_t tk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_ch.valid        <= 1;
    in_ch.opcode       <= op;
    in_ch.task_id      <= id;
    in_ch.priority_req <= pr;
    in_ch.delay_ticks  <= tk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_checked(op_t op, id_t id, prio_t pr, left_t tk);
    pending_results.push_back(schedule_step(op, id, pr, tk));
    send_request(op, id, pr, tk);
  endtask

  task automatic send_row(sched_row_t row);
    sched_res_t p;
    p = schedule_step(row.op, row.id, row.prio, row.ticks);
    if (row.has_exp && p != {row.e_run, row.e_task, row.e_prio, row.e_drop, row.e_done}) begin
      $display("%0t predictor disagrees with table row: expected %h got %h", $time,
               {row.e_run, row.e_task, row.e_prio, row.e_drop, row.e_done}, p);
      errors++;
    end
    pending_results.push_back(p);
    send_request(row.op, row.id, row.prio, row.ticks);
  endtask

  function automatic sched_row_t mk(op_t op, id_t id, prio_t pr, left_t tk);
    sched_row_t r;
    r = '{op: op, id: id, prio: pr, ticks: tk, default: 0};
    return r;
  endfunction

  function automatic sched_row_t mke(op_t op, id_t id, prio_t pr, left_t tk,
                                     bit rv, id_t t, prio_t p, bit d, bit dn);
    sched_row_t r;
    r = mk(op, id, pr, tk);
    r.has_exp = 1;
    r.e_run = rv; r.e_task = t; r.e_prio = p; r.e_drop = d; r.e_done = dn;
    return r;
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35)
        send_checked(OP_ADD, id_t'($urandom), prio_t'($urandom_range(0, 3) == 0 ?
                     $urandom_range(0, 3) : $urandom), '0);
      else if (r < 70)
        send_checked(OP_TICK, id_t'($urandom), prio_t'($urandom), left_t'($urandom));
      else if (r < 95)
        send_checked(OP_RERUN, id_t'($urandom), prio_t'($urandom),
                     $urandom_range(0, 3) == 0 ? left_t'(0) :
                     $urandom_range(0, 9) == 0 ? left_t'($urandom) :
                     left_t'($urandom_range(1, 6)));
      else
        send_checked(OP_NOP, id_t'($urandom), prio_t'($urandom), left_t'($urandom));
    end
  endtask

  always @(posedge clk) begin
    sched_res_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.run_valid, out_ch.run_task, out_ch.run_priority,
             out_ch.dropped, out_ch.all_done};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none got %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.run_valid !== want.run_valid || got.run_task !== want.run_task ||
            got.run_priority !== want.run_priority || got.dropped !== want.dropped ||
            got.all_done !== want.all_done) begin
          $display("%0t result mismatch: expected %h got %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    sched_row_t rows[$];
    errors = 0;
    idle_cycles = 0;
    rq_cnt = 0; dq_cnt = 0; cur_valid = 0; cur_id = 0; cur_prio = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.opcode = OP_NOP;
    in_ch.task_id = '0;
    in_ch.priority_req = '0;
    in_ch.delay_ticks = '0;
    out_ch.ready = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    rows.push_back(mke(OP_NOP,   8'h00, 8'h00, 10'd0, 0, 0, 0, 0, 1));
    rows.push_back(mke(OP_TICK,  8'h00, 8'h00, 10'd0, 0, 0, 0, 0, 1));
    rows.push_back(mke(OP_RERUN, 8'h00, 8'h00, 10'd5, 0, 0, 0, 0, 1));
    rows.push_back(mke(OP_ADD,   8'hff, 8'hff, 10'd0, 0, 0, 0, 0, 0));
    rows.push_back(mke(OP_TICK,  8'h00, 8'h00, 10'd0, 1, 8'hff, 8'hff, 0, 1));
    rows.push_back(mke(OP_RERUN, 8'h00, 8'h00, 10'd1023, 0, 0, 0, 0, 0));
    rows.push_back(mk(OP_RERUN,  8'h00, 8'h00, 10'd3));
    for (int i = 0; i < 9; i++)
      rows.push_back(mk(OP_ADD, id_t'(8'h10 + i), (i % 3 == 0) ? 8'h00 : 8'h80, 10'd0));
    rows.push_back(mk(OP_TICK,  8'h00, 8'h00, 10'd0));
    rows.push_back(mk(OP_RERUN, 8'h00, 8'h00, 10'd0));
    rows.push_back(mk(OP_TICK,  8'h00, 8'h00, 10'd0));
    rows.push_back(mk(OP_RERUN, 8'h00, 8'h00, 10'd1));
    rows.push_back(mk(OP_ADD,   8'h55, 8'h01, 10'd0));
    rows.push_back(mk(OP_TICK,  8'h00, 8'h00, 10'd0));
    rows.push_back(mk(OP_TICK,  8'haa, 8'haa, 10'h2aa));
    rows.push_back(mk(OP_NOP,   8'hff, 8'hff, 10'h3ff));
    foreach (rows[i]) send_row(rows[i]);

    for (int i = 0; i < 8; i++) begin
      send_checked(OP_ADD, id_t'(i), 8'h40, '0);
      send_checked(OP_TICK, '0, '0, '0);
      send_checked(OP_RERUN, '0, '0, 10'd1);
    end
    send_checked(OP_ADD, 8'h77, 8'h40, '0);
    send_checked(OP_TICK, '0, '0, '0);
    send_checked(OP_RERUN, '0, '0, 10'd1);
    for (int i = 0; i < 3; i++) send_checked(OP_TICK, '0, '0, '0);

    send_idle_pct = 32; recv_idle_pct = 82;
    random_phase(230);
    send_idle_pct = 82; recv_idle_pct = 32;
    random_phase(230);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(230);
    in_ch.valid <= 0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
